// File: src/dsfr_pkg.sv
// Shared types and constants for the dimmer serial frame receiver.
package dsfr_pkg;

  localparam logic [7:0] SYNC_FIRST      = 8'h55;
  localparam logic [7:0] SYNC_SECOND     = 8'hAA;
  localparam logic [5:0] MAX_FRAME_BYTES = 6'd52;
  localparam logic [5:0] DATA_IDX_FOUR   = 6'd4;
  localparam logic [5:0] DATA_IDX_SEVEN  = 6'd7;
  localparam logic [7:0] CMD_ACK         = 8'd5;
  localparam logic [7:0] CMD_STATE       = 8'd7;
  localparam logic [15:0] LEN_SWITCH     = 16'd5;
  localparam logic [15:0] LEN_LEVEL      = 16'd8;
  localparam logic [6:0] PCT_FULL        = 7'd100;

  localparam int NUM_W  = 15;
  localparam int SPAN_W = 8;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_VERSION,
    PH_COMMAND,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_BODY
  } parse_phase_e;

  typedef enum logic [1:0] {
    EV_IGNORED,
    EV_ACK,
    EV_SWITCH,
    EV_LEVEL
  } event_kind_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCALE,
    CS_DIV,
    CS_OUT
  } ctrl_state_e;

  typedef enum logic {
    CFG_LEVEL_MIN,
    CFG_LEVEL_MAX
  } cfg_reg_e;

  typedef struct packed {
    logic        done;
    logic [7:0]  command;
    logic [15:0] length;
    event_kind_e kind;
    logic        light_on;
    logic [7:0]  raw_level;
  } frame_t;

endpackage

// File: src/dsfr_parser.sv
// Byte-level frame parser that tracks the header and counts body bytes.
module dsfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_take_i,
  input  logic [7:0]        rx_byte_i,
  output dsfr_pkg::frame_t  frame_o
);

  dsfr_pkg::parse_phase_e phase_q, phase_d;
  logic [7:0]  command_q, command_d;
  logic [15:0] length_q, length_d;
  logic [5:0]  count_q, count_d;
  logic [7:0]  four_q, four_d;
  logic [7:0]  seven_q, seven_d;
  logic [5:0]  count_inc;
  logic        body_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dsfr_pkg::PH_HUNT_FIRST;
      command_q <= '0;
      length_q  <= '0;
      count_q   <= '0;
      four_q    <= '0;
      seven_q   <= '0;
    end else if (byte_take_i) begin
      phase_q   <= phase_d;
      command_q <= command_d;
      length_q  <= length_d;
      count_q   <= count_d;
      four_q    <= four_d;
      seven_q   <= seven_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    length_d  = length_q;
    count_d   = count_q;
    four_d    = (count_q == dsfr_pkg::DATA_IDX_FOUR) ? rx_byte_i : four_q;
    seven_d   = (count_q == dsfr_pkg::DATA_IDX_SEVEN) ? rx_byte_i : seven_q;
    count_inc = count_q + 6'd1;
    body_end  = ({10'd0, count_inc} > length_q) ||
                (count_inc >= dsfr_pkg::MAX_FRAME_BYTES);

    frame_o          = '0;
    frame_o.command  = command_q;
    frame_o.length   = length_q;
    frame_o.kind     = dsfr_pkg::EV_IGNORED;
    frame_o.raw_level = seven_d;

    if (command_q == dsfr_pkg::CMD_ACK) begin
      frame_o.kind = dsfr_pkg::EV_ACK;
    end else if (command_q == dsfr_pkg::CMD_STATE) begin
      if (length_q == dsfr_pkg::LEN_SWITCH) begin
        frame_o.kind     = dsfr_pkg::EV_SWITCH;
        frame_o.light_on = (four_d != 8'd0);
      end else if (length_q == dsfr_pkg::LEN_LEVEL) begin
        frame_o.kind = dsfr_pkg::EV_LEVEL;
      end
    end

    case (phase_q)
      dsfr_pkg::PH_HUNT_FIRST: begin
        four_d  = four_q;
        seven_d = seven_q;
        if (rx_byte_i == dsfr_pkg::SYNC_FIRST) phase_d = dsfr_pkg::PH_HUNT_SECOND;
      end
      dsfr_pkg::PH_HUNT_SECOND: begin
        four_d  = four_q;
        seven_d = seven_q;
        if (rx_byte_i == dsfr_pkg::SYNC_SECOND) phase_d = dsfr_pkg::PH_VERSION;
      end
      dsfr_pkg::PH_VERSION: begin
        four_d  = four_q;
        seven_d = seven_q;
        phase_d = dsfr_pkg::PH_COMMAND;
      end
      dsfr_pkg::PH_COMMAND: begin
        four_d    = four_q;
        seven_d   = seven_q;
        command_d = rx_byte_i;
        phase_d   = dsfr_pkg::PH_LEN_HIGH;
      end
      dsfr_pkg::PH_LEN_HIGH: begin
        four_d   = four_q;
        seven_d  = seven_q;
        length_d = {rx_byte_i, 8'd0};
        phase_d  = dsfr_pkg::PH_LEN_LOW;
      end
      dsfr_pkg::PH_LEN_LOW: begin
        four_d   = four_q;
        seven_d  = seven_q;
        length_d = {length_q[15:8], rx_byte_i};
        count_d  = '0;
        phase_d  = dsfr_pkg::PH_BODY;
      end
      dsfr_pkg::PH_BODY: begin
        count_d = count_inc;
        if (body_end) begin
          frame_o.done = 1'b1;
          phase_d      = dsfr_pkg::PH_HUNT_FIRST;
          count_d      = '0;
          length_d     = '0;
        end
      end
      default: begin
        four_d  = four_q;
        seven_d = seven_q;
        phase_d = dsfr_pkg::PH_HUNT_FIRST;
      end
    endcase
  end

endmodule

// File: src/dsfr_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module dsfr_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dsfr_pkg::NUM_W-1:0]    dividend_i,
  input  logic [dsfr_pkg::SPAN_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [dsfr_pkg::NUM_W-1:0]    quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [dsfr_pkg::STEP_W-1:0]   step_q, step_d;
  logic [dsfr_pkg::SPAN_W-1:0]   rem_q, rem_d;
  logic [dsfr_pkg::NUM_W-1:0]    dq_q, dq_d;
  logic [dsfr_pkg::SPAN_W-1:0]   dvs_q, dvs_d;
  logic [dsfr_pkg::SPAN_W:0]     shifted;
  logic [dsfr_pkg::SPAN_W:0]     diff;
  logic                          fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, dq_q[dsfr_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[dsfr_pkg::SPAN_W-1:0] : shifted[dsfr_pkg::SPAN_W-1:0];
      dq_d   = {dq_q[dsfr_pkg::NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == dsfr_pkg::LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// File: src/dimmer_serial_frame_receiver_unit.sv
// Top level of the dimmer serial frame receiver: sequencer, level scaling and output word.
// A byte that does not end a frame leaves the block ready again in the next cycle. A
// byte that ends a frame makes an output word valid in the next cycle, except for a
// level report, whose mapping runs the scaling state and then the restoring divider,
// so its word appears after the divider is done. When the raw level equals level_min,
// lies on the far side of it from level_max, or the range has zero width, the divider
// is skipped and the level report goes from the scaling state straight to the output
// state. No byte is taken while a word is pending; the block is ready again in the
// cycle after the word is taken.
module dimmer_serial_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_command_o,
  output logic [15:0] frame_length_o,
  output logic [1:0]  event_kind_o,
  output logic        light_on_o,
  output logic [6:0]  level_percent_o
);

  dsfr_pkg::ctrl_state_e state_q, state_d;
  dsfr_pkg::frame_t      frame;
  logic [7:0]  level_min_q, level_max_q;
  logic [7:0]  command_q, command_d;
  logic [15:0] length_q, length_d;
  dsfr_pkg::event_kind_e kind_q, kind_d;
  logic        on_q, on_d;
  logic [6:0]  pct_q, pct_d;
  logic [7:0]  raw_q, raw_d;
  logic        byte_take;
  logic        div_start;
  logic        div_done;
  logic [dsfr_pkg::NUM_W-1:0]  div_quot;
  logic signed [8:0]  diff_s;
  logic signed [8:0]  span_s;
  logic signed [15:0] num_s;
  logic [dsfr_pkg::NUM_W-1:0]  num_mag;
  logic [dsfr_pkg::SPAN_W-1:0] span_mag;

  assign byte_take = in_valid_i && in_ready_o;

  dsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_take_i (byte_take),
    .rx_byte_i   (rx_byte_i),
    .frame_o     (frame)
  );

  dsfr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (span_mag),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_min_q <= 8'd0;
      level_max_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsfr_pkg::CFG_LEVEL_MIN: level_min_q <= cfg_data_i;
        dsfr_pkg::CFG_LEVEL_MAX: level_max_q <= cfg_data_i;
        default: level_min_q <= level_min_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsfr_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    command_q <= command_d;
    length_q  <= length_d;
    kind_q    <= kind_d;
    on_q      <= on_d;
    pct_q     <= pct_d;
    raw_q     <= raw_d;
  end

  always_comb begin
    diff_s   = $signed({1'b0, raw_q}) - $signed({1'b0, level_min_q});
    span_s   = $signed({1'b0, level_max_q}) - $signed({1'b0, level_min_q});
    num_s    = 16'(diff_s) * 16'sd100;
    num_mag  = num_s[15] ? dsfr_pkg::NUM_W'(-num_s) : num_s[dsfr_pkg::NUM_W-1:0];
    span_mag = span_s[8] ? dsfr_pkg::SPAN_W'(-span_s) : span_s[dsfr_pkg::SPAN_W-1:0];
  end

  always_comb begin
    state_d   = state_q;
    command_d = command_q;
    length_d  = length_q;
    kind_d    = kind_q;
    on_d      = on_q;
    pct_d     = pct_q;
    raw_d     = raw_q;
    div_start = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dsfr_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && frame.done) begin
          command_d = frame.command;
          length_d  = frame.length;
          kind_d    = frame.kind;
          on_d      = frame.light_on;
          raw_d     = frame.raw_level;
          pct_d     = '0;
          state_d   = (frame.kind == dsfr_pkg::EV_LEVEL) ? dsfr_pkg::CS_SCALE
                                                         : dsfr_pkg::CS_OUT;
        end
      end
      dsfr_pkg::CS_SCALE: begin
        if (span_s == 9'sd0 || diff_s == 9'sd0 || (diff_s[8] != span_s[8])) begin
          state_d = dsfr_pkg::CS_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = dsfr_pkg::CS_DIV;
        end
      end
      dsfr_pkg::CS_DIV: begin
        if (div_done) begin
          pct_d   = (div_quot > dsfr_pkg::NUM_W'(dsfr_pkg::PCT_FULL)) ? dsfr_pkg::PCT_FULL
                                                                      : div_quot[6:0];
          state_d = dsfr_pkg::CS_OUT;
        end
      end
      dsfr_pkg::CS_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = dsfr_pkg::CS_IDLE;
      end
      default: begin
        state_d = dsfr_pkg::CS_IDLE;
      end
    endcase
  end

  assign frame_command_o = command_q;
  assign frame_length_o  = length_q;
  assign event_kind_o    = kind_q;
  assign light_on_o      = on_q;
  assign level_percent_o = pct_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while an output word is pending.");

  a_div_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == dsfr_pkg::CS_DIV))
    else $error("Divider finished outside the divide state.");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_percent_o <= dsfr_pkg::PCT_FULL))
    else $error("Level percent above full scale.");

  a_pct_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o != dsfr_pkg::EV_LEVEL)) |-> (level_percent_o == 7'd0))
    else $error("Level percent set for a word that is not a level report.");

endmodule
